/* sv/imvm_pkg.sv */
`timescale 1ns / 1ps

package imvm_pkg;

    localparam int ValueW     = 32;
    localparam int RowW       = 8;
    localparam int OrderW     = 9;
    localparam int QueueDepth = 8;
    localparam int QueueAw    = $clog2(QueueDepth);
    localparam int CountW     = $clog2(QueueDepth + 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_MATRIX = 1'b1
    } t_op;

    // One matrix element on its way from the front end to the multiply stage.
    typedef struct packed {
        logic              valid;
        logic              last_col;
        logic              last_row;
        logic [RowW-1:0]   row;
        logic [ValueW-1:0] value;
    } t_elem;

    typedef struct packed {
        logic [RowW-1:0]   row_index;
        logic [ValueW-1:0] row_sum;
        logic              last_row;
    } t_result;

endpackage

/* sv/imvm_ram.sv */
`timescale 1ns / 1ps

module imvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/imvm_front.sv */
`timescale 1ns / 1ps

module imvm_front #(
    parameter int MAX_ORDER = 256
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [imvm_pkg::OrderW-1:0]  i_cfg_wdata,
    input  logic                         i_accept,
    input  imvm_pkg::t_op                i_op,
    input  logic [imvm_pkg::ValueW-1:0]  i_value,
    output imvm_pkg::t_elem              o_elem,
    output logic [imvm_pkg::ValueW-1:0]  o_vec
);

    import imvm_pkg::*;

    localparam int AW = $clog2(MAX_ORDER);

    logic [AW-1:0] r_last_idx, n_last_idx;
    logic [AW-1:0] r_load_ptr;
    logic [AW-1:0] r_col;
    logic [AW-1:0] r_row;
    logic          r_valid;
    logic          r_last_col;
    logic          r_last_row;
    logic [RowW-1:0]   r_row_out;
    logic [ValueW-1:0] r_value;

    logic w_load, w_matrix, w_col_end, w_row_end;

    assign w_load    = i_accept && (i_op == OP_LOAD);
    assign w_matrix  = i_accept && (i_op == OP_MATRIX);
    assign w_col_end = (r_col == r_last_idx);
    assign w_row_end = (r_row == r_last_idx);

    // An order of zero behaves as one; anything past the store size is clamped.
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_last_idx = '0;
        end else if (int'(i_cfg_wdata) > MAX_ORDER) begin
            n_last_idx = AW'(MAX_ORDER - 1);
        end else begin
            n_last_idx = AW'(i_cfg_wdata - OrderW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= '0;
            r_load_ptr <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_valid <= w_matrix;
            if (i_cfg_we) begin
                r_last_idx <= n_last_idx;
                r_load_ptr <= '0;
                r_col      <= '0;
                r_row      <= '0;
            end else if (w_load) begin
                r_load_ptr <= (r_load_ptr == r_last_idx) ? '0 : r_load_ptr + AW'(1);
            end else if (w_matrix) begin
                r_col <= w_col_end ? '0 : r_col + AW'(1);
                if (w_col_end) begin
                    r_row <= w_row_end ? '0 : r_row + AW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_matrix) begin
            r_last_col <= w_col_end;
            r_last_row <= w_row_end;
            r_row_out  <= RowW'(r_row);
            r_value    <= i_value;
        end
    end

    // A load written at one edge is seen by a matrix element read at the next.
    imvm_ram #(
        .WIDTH (ValueW),
        .DEPTH (MAX_ORDER)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (r_load_ptr),
        .i_wdata (i_value),
        .i_re    (w_matrix),
        .i_raddr (r_col),
        .o_rdata (o_vec)
    );

    always_comb begin
        o_elem.valid    = r_valid;
        o_elem.last_col = r_last_col;
        o_elem.last_row = r_last_row;
        o_elem.row      = r_row_out;
        o_elem.value    = r_value;
    end

endmodule

/* sv/imvm_mac.sv */
`timescale 1ns / 1ps

module imvm_mac (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  imvm_pkg::t_elem              i_elem,
    input  logic [imvm_pkg::ValueW-1:0]  i_vec,
    output logic                         o_push,
    output imvm_pkg::t_result            o_result,
    output logic                         o_pending
);

    import imvm_pkg::*;

    logic              r_valid;
    logic              r_last_col;
    logic              r_last_row;
    logic [RowW-1:0]   r_row;
    logic [ValueW-1:0] r_prod;
    logic [ValueW-1:0] r_sum;
    logic [ValueW-1:0] n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_elem.valid;
        end
    end

    // Only the low 32 bits are kept, which is the same for signed and unsigned.
    always_ff @(posedge i_clk) begin
        if (i_elem.valid) begin
            r_last_col <= i_elem.last_col;
            r_last_row <= i_elem.last_row;
            r_row      <= i_elem.row;
            r_prod     <= ValueW'(i_elem.value * i_vec);
        end
    end

    assign n_sum = r_sum + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cfg_we) begin
            r_sum <= '0;
        end else if (r_valid) begin
            r_sum <= r_last_col ? '0 : n_sum;
        end
    end

    assign o_push    = r_valid && r_last_col;
    assign o_pending = o_push;

    always_comb begin
        o_result.row_index = r_row;
        o_result.row_sum   = n_sum;
        o_result.last_row  = r_last_row;
    end

endmodule

/* sv/imvm_queue.sv */
`timescale 1ns / 1ps

module imvm_queue (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  imvm_pkg::t_result            i_data,
    output logic                         o_valid,
    input  logic                         i_ready,
    output imvm_pkg::t_result            o_data,
    output logic [imvm_pkg::CountW-1:0]  o_count
);

    import imvm_pkg::*;

    t_result             r_mem [QueueDepth];
    logic [QueueAw-1:0]  r_wr_ptr;
    logic [QueueAw-1:0]  r_rd_ptr;
    logic [CountW-1:0]   r_count;
    logic                w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QueueAw'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + QueueAw'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + CountW'(1);
            end else if (w_pop && !i_push) begin
                r_count <= r_count - CountW'(1);
            end
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

/* sv/integer_matrix_vector_multiply.sv */
`timescale 1ns / 1ps

// Streaming square matrix times vector, 32-bit integers with wrapping sums.
// Write the matrix order on i_cfg_we/i_cfg_wdata while the block is idle; the
// write also restarts row and column positions but keeps the stored vector.
// Input items: tuser[0] = 0 loads the next vector element, 1 supplies the next
// matrix element in row-major order; tdata carries the 32-bit signed value.
// Each finished row gives one output item with the row index, the dot product
// and tlast set on the final row of the matrix.
// A row's last element passes the vector RAM read and front-end register,
// then the registered multiplier, then the result queue, before tvalid.
// Throughput is one item per cycle while s_axis tready is high, of either kind.
// Results wait in an 8-entry queue; when the queue plus the rows still in the
// multiply pipeline would fill it, s_axis tready drops until the receiver
// takes items again. Reset clears the pipeline, queue, counters and the order
// (back to one); the vector RAM is not cleared and needs no clearing pass.
module integer_matrix_vector_multiply #(
    parameter int MAX_ORDER = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [8:0]  i_cfg_wdata,     // order
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,  // [31:0] value
    input  logic [0:0]  i_s_axis_tuser,  // [0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [39:0] o_m_axis_tdata,  // [7:0] row_index, [39:8] row_sum
    output logic        o_m_axis_tlast   // last_row
);

    import imvm_pkg::*;

    t_elem             w_elem;
    logic [ValueW-1:0] w_vec;
    logic              w_push;
    logic              w_pending;
    t_result           w_result;
    t_result           w_out;
    logic [CountW-1:0] w_count;
    logic [CountW-1:0] w_fill;
    logic              w_accept;

    // Every row that may still finish needs a queue slot reserved up front.
    assign w_fill = w_count + CountW'(w_elem.valid && w_elem.last_col) + CountW'(w_pending);
    assign o_s_axis_tready = (w_fill < CountW'(QueueDepth));
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    imvm_front #(
        .MAX_ORDER (MAX_ORDER)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (w_accept),
        .i_op        (t_op'(i_s_axis_tuser[0])),
        .i_value     (i_s_axis_tdata),
        .o_elem      (w_elem),
        .o_vec       (w_vec)
    );

    imvm_mac u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_elem    (w_elem),
        .i_vec     (w_vec),
        .o_push    (w_push),
        .o_result  (w_result),
        .o_pending (w_pending)
    );

    imvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (w_out),
        .o_count (w_count)
    );

    assign o_m_axis_tdata = {w_out.row_sum, w_out.row_index};
    assign o_m_axis_tlast = w_out.last_row;

endmodule

/* sv/imvm_checker.sv */
`timescale 1ns / 1ps

module imvm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic [0:0]  i_s_axis_tuser,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [39:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    logic w_matrix_accept;

    assign w_matrix_accept = i_s_axis_tvalid && o_s_axis_tready && i_s_axis_tuser[0];

    // Nothing is left over in the queue once reset has been applied.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output item changed");

    // With the queue empty, a new result traces back to an accepted matrix item.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> $past(w_matrix_accept, 3))
        else $error("result without a matching matrix item");

endmodule

bind integer_matrix_vector_multiply imvm_checker u_imvm_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
    import imvm_pkg::*;

    localparam int QuietLimit = 5000;
    localparam int HoldCycles = 300;

    typedef struct {
        t_op         op;
        logic [31:0] value;
    } t_feed_item;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [8:0]  cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    integer_matrix_vector_multiply uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),   // [31:0] value
        .i_s_axis_tuser  (s_tuser),   // [0] op
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),   // [7:0] row_index, [39:8] row_sum
        .o_m_axis_tlast  (m_tlast)    // last_row
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Shadow of the block: stored vector, positions, running sum and order.
    logic [31:0] vec_ram [256];
    logic [8:0]  order_q = 9'd1;
    int          ld_ptr;
    int          col_cnt;
    int          row_cnt;
    logic [31:0] acc;

    t_result     row_results_due[$];
    t_feed_item  feed_q[$];
    t_feed_item  cur;

    int errors = 0;
    int items_pushed = 0;
    int items_accepted = 0;
    int rows_checked = 0;
    int order_writes = 0;
    int burst_left = 0;
    int gap_left = 0;
    int rx_cycle = 0;
    int rx_mode = 0;
    int hold_left = 0;
    bit hold_go = 1'b0;
    bit hold_done = 1'b0;
    int quiet = 0;

    function automatic int eff_order(input logic [8:0] o);
        if (o == 0) return 1;
        if (o > 256) return 256;
        return int'(o);
    endfunction

    task automatic restart_job();
        ld_ptr = 0;
        col_cnt = 0;
        row_cnt = 0;
        acc = '0;
    endtask

    task automatic predict_row(input t_op op, input logic [31:0] v);
        int      n;
        t_result r;
        n = eff_order(order_q);
        if (op == OP_LOAD) begin
            if (ld_ptr >= n) ld_ptr = 0;
            vec_ram[ld_ptr] = v;
            ld_ptr++;
            if (ld_ptr >= n) ld_ptr = 0;
        end else begin
            if (col_cnt >= n) col_cnt = 0;
            if (row_cnt >= n) row_cnt = 0;
            acc = acc + v * vec_ram[col_cnt];
            col_cnt++;
            if (col_cnt == n) begin
                r.row_index = row_cnt[7:0];
                r.row_sum   = acc;
                r.last_row  = (row_cnt + 1 >= n);
                row_results_due.push_back(r);
                col_cnt = 0;
                acc = '0;
                row_cnt = r.last_row ? 0 : row_cnt + 1;
            end
        end
    endtask

    // Driver: bursts of random length separated by random gaps.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_row(cur.op, cur.value);
                items_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0 || feed_q.size() == 0) begin
                    if (gap_left > 0) gap_left--;
                    s_tvalid <= 1'b0;
                end else begin
                    cur = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= cur.value;
                    s_tuser <= cur.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    task automatic check_row();
        t_result want;
        if (row_results_due.size() == 0) begin
            $error("unexpected row result: row_index %0d row_sum %0d",
                   m_tdata[7:0], $signed(m_tdata[39:8]));
            errors++;
        end else begin
            want = row_results_due.pop_front();
            if (m_tdata[7:0] !== want.row_index) begin
                $error("row_index: expected %0d, got %0d", want.row_index, m_tdata[7:0]);
                errors++;
            end
            if (m_tdata[39:8] !== want.row_sum) begin
                $error("row_sum: expected %0d, got %0d",
                       $signed(want.row_sum), $signed(m_tdata[39:8]));
                errors++;
            end
            if (m_tlast !== want.last_row) begin
                $error("last_row: expected %0b, got %0b", want.last_row, m_tlast);
                errors++;
            end
        end
        rows_checked++;
    endtask

    // Monitor: checks results and stalls on its own changing pattern.
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) check_row();
            rx_cycle++;
            if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 3);
            if (hold_go && !hold_done) begin
                hold_left = HoldCycles;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= rx_cycle[2];
                endcase
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n) begin
            quiet <= 0;
        end else if (quiet >= QuietLimit) begin
            $display("tb: done, errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(0, 200) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic push(input t_op op, input logic [31:0] v);
        t_feed_item it;
        it.op = op;
        it.value = v;
        feed_q.push_back(it);
        items_pushed++;
    endtask

    // Waits until every item is taken and every row has come out, then lets a
    // partial row or trailing loads clear the pipeline.
    task automatic wait_drain();
        while (items_accepted != items_pushed || row_results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_order(input logic [8:0] v);
        wait_drain();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        order_q = v;
        restart_job();
        order_writes++;
    endtask

    initial begin
        int loaded_upto;
        int rand_start;
        int sel;
        int ord;
        int n;
        int extra;
        int rows;
        int cells;

        restart_job();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Reset order is one: the most negative value squared wraps to zero.
        push(OP_LOAD, 32'h8000_0000);
        push(OP_MATRIX, 32'h8000_0000);
        push(OP_LOAD, 32'h7FFF_FFFF);
        push(OP_MATRIX, 32'hFFFF_FFFF);
        loaded_upto = 1;

        // Order three, with a load in the middle of the matrix that overwrites
        // element zero after the pointer has wrapped.
        write_order(9'd3);
        push(OP_LOAD, 32'd5);
        push(OP_LOAD, 32'hFFFF_FFFF);
        push(OP_LOAD, 32'h7FFF_FFFF);
        push(OP_MATRIX, 32'h7FFF_FFFF);
        push(OP_MATRIX, 32'h7FFF_FFFF);
        push(OP_MATRIX, 32'd2);
        push(OP_LOAD, 32'd9);
        push(OP_MATRIX, 32'd1);
        push(OP_MATRIX, 32'h8000_0000);
        push(OP_MATRIX, 32'd1);
        push(OP_MATRIX, 32'hFFFF_FFFF);
        push(OP_MATRIX, 32'd0);
        push(OP_MATRIX, 32'd3);
        loaded_upto = 3;

        // Zero behaves as order one; the stored vector survives the write.
        write_order(9'd0);
        push(OP_MATRIX, 32'd4);
        push(OP_MATRIX, 32'hFFFF_FFFB);

        // All-ones order clamps to the largest: one full vector load.
        write_order(9'h1FF);
        for (int i = 0; i < 256; i++) push(OP_LOAD, pick_value());
        loaded_upto = 256;

        // Largest order: one row over the stored vector, with a few loads.
        write_order(9'd256);
        for (int i = 0; i < 256; i++) begin
            if (i % 50 == 0) push(OP_LOAD, pick_value());
            push(OP_MATRIX, pick_value());
        end

        // Receiver holds off while short rows keep coming, so the result
        // queue fills and the input side has to stall.
        write_order(9'd1);
        hold_go = 1'b1;
        for (int i = 0; i < 80; i++) push(OP_MATRIX, pick_value());

        rand_start = items_pushed;
        while (items_pushed - rand_start < 130) begin
            sel = $urandom_range(0, 19);
            if (sel < 12) ord = $urandom_range(1, 8);
            else if (sel < 17) ord = $urandom_range(9, 32);
            else if (sel < 19) ord = 0;
            else ord = $urandom_range(2, 16);
            write_order(ord[8:0]);
            n = (ord == 0) ? 1 : ord;
            if (n > loaded_upto || $urandom_range(0, 1) == 1) begin
                extra = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n + 2) : 0;
                for (int i = 0; i < n + extra; i++) push(OP_LOAD, pick_value());
                if (n > loaded_upto) loaded_upto = n;
            end
            rows = $urandom_range(1, (n <= 4) ? 8 : 3);
            cells = rows * n + (($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : 0);
            for (int i = 0; i < cells; i++) begin
                if ($urandom_range(0, 11) == 0) push(OP_LOAD, pick_value());
                push(OP_MATRIX, pick_value());
            end
        end

        wait_drain();
        if (row_results_due.size() != 0) errors++;
        $display("tb: %0d items over %0d order writes, %0d row results compared",
                 items_accepted, order_writes, rows_checked);
        $display("tb: orders covered one through 32, zero and clamped, plus 256");
        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/imvm_pkg.sv
sv/imvm_ram.sv
sv/imvm_front.sv
sv/imvm_mac.sv
sv/imvm_queue.sv
sv/integer_matrix_vector_multiply.sv
sv/imvm_checker.sv
tb/tb.sv
